[rtl/ir_pulse_distance_transmitter_macros.svh]
// ----------------------------------------------------------------------------
// IR pulse-distance transmitter assertion macros
// Concurrent assertion wrappers; empty when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_MACROS_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_MACROS_SVH

`ifndef ASSERT_OFF
`define IRPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IRPD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define IRPD_ASSERT(lbl, clk, rstn, prop, msg)
`define IRPD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[rtl/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, codes and reset values of the IR pulse-distance transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 16;
  localparam int unsigned NUM_REGS        = 7;

  localparam logic [1:0] OP_BYTE_WRITE = 2'd0;
  localparam logic [1:0] OP_START      = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BUSY     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [2:0] REG_LEAD_DELAY  = 3'd0;
  localparam logic [2:0] REG_START_MARK  = 3'd1;
  localparam logic [2:0] REG_START_SPACE = 3'd2;
  localparam logic [2:0] REG_BIT_MARK    = 3'd3;
  localparam logic [2:0] REG_ZERO_SPACE  = 3'd4;
  localparam logic [2:0] REG_ONE_SPACE   = 3'd5;
  localparam logic [2:0] REG_STOP_MARK   = 3'd6;

  localparam logic [7:0] CFG_RESET [NUM_REGS] = '{
    8'd100, 8'd5, 8'd5, 8'd2, 8'd1, 8'd2, 8'd5
  };

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] byte_slot;
    logic [7:0] byte_value;
    logic [7:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic       carrier_on;
    logic       busy_res;
    logic [1:0] status;
    logic       frame_done;
  } out_item_t;

  typedef enum logic [3:0] {
    CNT_HOLD,
    CNT_DEC,
    CNT_LEAD,
    CNT_START_MARK,
    CNT_START_SPACE,
    CNT_BIT_MARK,
    CNT_ZERO_SPACE,
    CNT_ONE_SPACE,
    CNT_STOP_MARK
  } cnt_op_e;

  typedef struct packed {
    logic       res_valid;
    logic       wr_req;
    logic       arm;
    logic       bit_adv;
    logic       carrier_set;
    logic       carrier_clr;
    cnt_op_e    cnt_op;
    logic [1:0] status;
    logic       done;
    logic       busy;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_le1;
    logic bit_last;
    logic byte_last;
    logic cur_bit;
    logic len_zero;
    logic len_long;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/irpd_ram.sv]
// ----------------------------------------------------------------------------
// irpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/irpd_ctrl.sv]
// ----------------------------------------------------------------------------
// irpd_ctrl
// Frame sequencer: decodes items and steps the symbol phases on timer expiry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ir_pulse_distance_transmitter_macros.svh"

module irpd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           opcode_i,
  input  wire irpd_pkg::dp_stat_t   stat_i,
  output irpd_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_BIT,
    PH_STOP
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] hs_q, hs_d;

  always_comb begin
    phase_d = phase_q;
    hs_d    = hs_q;
    cmd_o   = '{cnt_op: irpd_pkg::CNT_HOLD, status: irpd_pkg::STATUS_OK, default: 1'b0};

    if (accept_i) begin
      cmd_o.res_valid = 1'b1;
      unique case (opcode_i)
        irpd_pkg::OP_BYTE_WRITE: begin
          cmd_o.wr_req = (phase_q == PH_IDLE);
        end
        irpd_pkg::OP_START: begin
          if (phase_q != PH_IDLE) begin
            cmd_o.status = irpd_pkg::STATUS_BUSY;
          end else if (stat_i.len_long) begin
            cmd_o.status = irpd_pkg::STATUS_TOO_LONG;
          end else if (!stat_i.len_zero) begin
            cmd_o.arm    = 1'b1;
            cmd_o.cnt_op = irpd_pkg::CNT_LEAD;
            phase_d      = PH_START;
            hs_d         = 2'd0;
          end
        end
        irpd_pkg::OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (!stat_i.cnt_le1) begin
              cmd_o.cnt_op = irpd_pkg::CNT_DEC;
            end else if (phase_q == PH_STOP) begin
              phase_d           = PH_IDLE;
              cmd_o.carrier_clr = 1'b1;
              cmd_o.done        = 1'b1;
            end else if (hs_q >= 2'd2) begin
              // symbol complete: next bit, or stop mark after the last one
              cmd_o.carrier_set = 1'b1;
              cmd_o.bit_adv     = (phase_q == PH_BIT);
              if (phase_q == PH_BIT && stat_i.bit_last && stat_i.byte_last) begin
                phase_d      = PH_STOP;
                hs_d         = 2'd0;
                cmd_o.cnt_op = irpd_pkg::CNT_STOP_MARK;
              end else begin
                phase_d      = PH_BIT;
                hs_d         = 2'd1;
                cmd_o.cnt_op = irpd_pkg::CNT_BIT_MARK;
              end
            end else if (hs_q == 2'd0) begin
              cmd_o.carrier_set = 1'b1;
              hs_d              = 2'd1;
              cmd_o.cnt_op      = (phase_q == PH_START) ? irpd_pkg::CNT_START_MARK
                                                         : irpd_pkg::CNT_BIT_MARK;
            end else begin
              cmd_o.carrier_clr = 1'b1;
              hs_d              = 2'd2;
              if (phase_q == PH_START) begin
                cmd_o.cnt_op = irpd_pkg::CNT_START_SPACE;
              end else if (stat_i.cur_bit) begin
                cmd_o.cnt_op = irpd_pkg::CNT_ONE_SPACE;
              end else begin
                cmd_o.cnt_op = irpd_pkg::CNT_ZERO_SPACE;
              end
            end
          end
        end
        default: ;
      endcase
    end

    cmd_o.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hs_q    <= 2'd0;
    end else begin
      phase_q <= phase_d;
      hs_q    <= hs_d;
    end
  end

  `IRPD_ASSERT(a_done_from_stop, clk_i, rst_ni, cmd_o.done |-> phase_q == PH_STOP, "done outside stop")
  `IRPD_ASSERT(a_arm_loads_lead, clk_i, rst_ni, cmd_o.arm |-> phase_q == PH_IDLE && cmd_o.cnt_op == irpd_pkg::CNT_LEAD, "bad arm")
  `IRPD_ASSERT(a_stop_half_clear, clk_i, rst_ni, phase_q == PH_STOP |-> hs_q == 2'd0, "stop with half set")
  `IRPD_ASSERT_NEVER(a_half_range, clk_i, rst_ni, hs_q == 2'd3, "half symbol out of range")

endmodule

`default_nettype wire

[rtl/irpd_dp.sv]
// ----------------------------------------------------------------------------
// irpd_dp
// Datapath: config registers, frame buffer, tick timer, positions, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ir_pulse_distance_transmitter_macros.svh"

module irpd_dp #(
  parameter int unsigned FRAME_BYTES = irpd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire irpd_pkg::in_item_t   item_i,
  input  wire irpd_pkg::ctrl_cmd_t  cmd_i,
  output irpd_pkg::dp_stat_t        stat_o,
  output irpd_pkg::out_item_t       result_o,
  output logic                      result_valid_o
);

  localparam int unsigned AW   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned FB_W = $clog2(FRAME_BYTES + 1);

  logic [7:0]      cfg_q [irpd_pkg::NUM_REGS];
  logic [7:0]      cnt_q, cnt_d;
  logic [2:0]      bit_pos_q, bit_pos_d;
  logic [FB_W-1:0] byte_pos_q, byte_pos_d;
  logic [FB_W-1:0] frame_bytes_q;
  logic            carrier_q, carrier_d;
  logic            ram_we;
  logic [7:0]      ram_rdata;
  irpd_pkg::out_item_t result_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= irpd_pkg::CFG_RESET;
    end else if (cfg_we_i && int'(cfg_index_i) < irpd_pkg::NUM_REGS) begin
      cfg_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  assign ram_we = cmd_i.wr_req && (int'(item_i.byte_slot) < FRAME_BYTES);

  irpd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(item_i.byte_slot)),
    .wdata_i (item_i.byte_value),
    .raddr_i (byte_pos_d[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (cmd_i.cnt_op)
      irpd_pkg::CNT_HOLD:        cnt_d = cnt_q;
      irpd_pkg::CNT_DEC:         cnt_d = cnt_q - 8'd1;
      irpd_pkg::CNT_LEAD:        cnt_d = cfg_q[irpd_pkg::REG_LEAD_DELAY];
      irpd_pkg::CNT_START_MARK:  cnt_d = cfg_q[irpd_pkg::REG_START_MARK];
      irpd_pkg::CNT_START_SPACE: cnt_d = cfg_q[irpd_pkg::REG_START_SPACE];
      irpd_pkg::CNT_BIT_MARK:    cnt_d = cfg_q[irpd_pkg::REG_BIT_MARK];
      irpd_pkg::CNT_ZERO_SPACE:  cnt_d = cfg_q[irpd_pkg::REG_ZERO_SPACE];
      irpd_pkg::CNT_ONE_SPACE:   cnt_d = cfg_q[irpd_pkg::REG_ONE_SPACE];
      irpd_pkg::CNT_STOP_MARK:   cnt_d = cfg_q[irpd_pkg::REG_STOP_MARK];
      default:                   cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    bit_pos_d  = bit_pos_q;
    byte_pos_d = byte_pos_q;
    if (cmd_i.arm) begin
      bit_pos_d  = 3'd0;
      byte_pos_d = '0;
    end else if (cmd_i.bit_adv) begin
      bit_pos_d = bit_pos_q + 3'd1;
      if (bit_pos_q == 3'd7) begin
        byte_pos_d = byte_pos_q + FB_W'(1);
      end
    end
  end

  always_comb begin
    carrier_d = carrier_q;
    if (cmd_i.carrier_set) begin
      carrier_d = 1'b1;
    end else if (cmd_i.carrier_clr) begin
      carrier_d = 1'b0;
    end
  end

  always_comb begin
    stat_o.cnt_le1   = (cnt_q <= 8'd1);
    stat_o.bit_last  = (bit_pos_q == 3'd7);
    stat_o.byte_last = ((FB_W + 1)'(byte_pos_q) + (FB_W + 1)'(1))
                       >= (FB_W + 1)'(frame_bytes_q);
    stat_o.cur_bit   = ram_rdata[bit_pos_q];
    stat_o.len_zero  = (item_i.frame_length == 8'd0);
    stat_o.len_long  = (int'(item_i.frame_length) > FRAME_BYTES);
  end

  assign result_d = '{
    carrier_on: carrier_d,
    busy_res:   cmd_i.busy,
    status:     cmd_i.status,
    frame_done: cmd_i.done
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= 8'd0;
      bit_pos_q      <= 3'd0;
      byte_pos_q     <= '0;
      frame_bytes_q  <= '0;
      carrier_q      <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      cnt_q          <= cnt_d;
      bit_pos_q      <= bit_pos_d;
      byte_pos_q     <= byte_pos_d;
      carrier_q      <= carrier_d;
      result_valid_o <= cmd_i.res_valid;
      if (cmd_i.arm) begin
        frame_bytes_q <= FB_W'(item_i.frame_length);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_valid) begin
      result_o <= result_d;
    end
  end

  `IRPD_ASSERT(a_idle_dark, clk_i, rst_ni, result_valid_o && !result_o.busy_res |-> !result_o.carrier_on, "carrier on while idle")

endmodule

`default_nettype wire

[rtl/ir_pulse_distance_transmitter.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter
// IR pulse-distance frame transmitter gating a carrier from a 16-byte buffer.
// ----------------------------------------------------------------------------
// Results: the result of an item is registered and is on result_o in the cycle after it is taken.
// Throughput: one item per cycle; busy stays low, every item is one state step.
// The frame buffer read is registered and prefetched as the bit position moves.
// Reset: async, active low; registers return to defaults, sequencer idle,
// carrier off. Frame buffer contents are undefined until written.
`default_nettype none

module ir_pulse_distance_transmitter #(
  parameter int unsigned FRAME_BYTES = irpd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire irpd_pkg::in_item_t  item_i,
  output irpd_pkg::out_item_t      result_o,
  output logic                     result_valid_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_wdata_i
);

  logic                accept;
  irpd_pkg::ctrl_cmd_t cmd;
  irpd_pkg::dp_stat_t  stat;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  irpd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (item_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  irpd_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire
